// ===== design/xks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xks_pkg;

   localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] ZERO_KEY_SUBST   = 64'hA5A5_A5A5_A5A5_A5A5;
   localparam int unsigned XS_SHIFT_A = 12;
   localparam int unsigned XS_SHIFT_B = 25;
   localparam int unsigned XS_SHIFT_C = 27;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY           = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_HASH = 2'd2;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [63:0] running_hash;
      logic        hash_match;
      logic        end_of_string;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic        direction;
      logic [63:0] expected_hash;
   } cfg_type;

   typedef struct packed {
      logic [63:0] gen;
      logic [7:0]  idx;
      logic [63:0] hash;
   } state_type;

   // x * 0x100000001B3 as shifts and adds (bits 40, 8, 7, 5, 4, 1, 0)
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      logic [63:0] lo;
      lo = (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
      return (x << 40) + (x << 8) + lo;
   endfunction

endpackage

`default_nettype wire

// ===== design/xks_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xks_csr
   import xks_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY:           cfg_in.key           = csr_data;
            CSR_DIRECTION:     cfg_in.direction     = csr_data[0];
            CSR_EXPECTED_HASH: cfg_in.expected_hash = csr_data;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key           <= ZERO_KEY_SUBST;
         cfg_ff.direction     <= DIR_ENCODE;
         cfg_ff.expected_hash <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/xks_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xks_datapath
   import xks_pkg::*;
(
   input  req_type   item,
   input  cfg_type   cfg,
   input  state_type cur,
   output state_type nxt,
   output rsp_type   rsp
);

   logic [63:0] seed;
   state_type   base;
   logic [63:0] xs_a;
   logic [63:0] xs_b;
   logic [63:0] xs_c;
   logic [7:0]  ks;
   logic [7:0]  obyte;
   logic [7:0]  plain;
   logic [63:0] hash_next;

   assign seed = (cfg.key != 64'd0) ? cfg.key : ZERO_KEY_SUBST;

   always_comb begin
      base = cur;
      if (item.first) begin
         base.gen  = seed;
         base.idx  = 8'd0;
         base.hash = FNV_OFFSET_BASIS;
      end
   end

   assign xs_a = base.gen ^ (base.gen >> XS_SHIFT_A);
   assign xs_b = xs_a ^ (xs_a << XS_SHIFT_B);
   assign xs_c = xs_b ^ (xs_b >> XS_SHIFT_C);

   assign ks        = xs_c[7:0] ^ base.idx;
   assign obyte     = item.data_byte ^ ks;
   assign plain     = (cfg.direction == DIR_DECODE) ? obyte : item.data_byte;
   assign hash_next = fnv_mul(base.hash ^ {56'd0, plain});

   always_comb begin
      nxt.gen  = xs_c;
      nxt.idx  = base.idx + 8'd1;
      nxt.hash = hash_next;
   end

   always_comb begin
      rsp.out_byte      = obyte;
      rsp.running_hash  = hash_next;
      rsp.hash_match    = item.last && (hash_next == cfg.expected_hash);
      rsp.end_of_string = item.last;
   end

endmodule

`default_nettype wire

// ===== design/xorshift_keystream_string_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A request is captured in the input register; its result is registered in the
// output register once that is free. Throughput: one request per cycle while the
// result is not stalled; the datapath's generator/hash update is combinational.
// A stalled result keeps one more request in the input register.
// Synchronous reset: empties both registers, loads generator, index, hash
// and configuration with their initial values.
module xorshift_keystream_string_cipher_core
   import xks_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  req_type                     req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   cfg_type   cfg;
   logic      in_valid_ff;
   req_type   in_req_ff;
   logic      out_valid_ff;
   rsp_type   out_rsp_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   logic      out_free;
   logic      advance;
   logic      req_take;

   xks_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   xks_datapath u_datapath (
      .item (in_req_ff),
      .cfg  (cfg),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.gen  <= ZERO_KEY_SUBST;
         state_ff.idx  <= 8'd0;
         state_ff.hash <= FNV_OFFSET_BASIS;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   a_first_restarts_index: assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.first |=> state_ff.idx == 8'd1)
      else $error("index not restarted by first byte");

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("string state changed without a request");

   a_match_only_on_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.hash_match |-> out_rsp_ff.end_of_string)
      else $error("hash match flagged before end of string");

   a_generator_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.gen != 64'd0)
      else $error("generator state became zero");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_req_ff))
      else $error("held request lost while result stalled");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

import xks_pkg::*;

localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

typedef logic [7:0] byte_q[$];

function automatic logic [63:0] xs_next(input logic [63:0] s);
   s = s ^ (s >> XS_SHIFT_A);
   s = s ^ (s << XS_SHIFT_B);
   s = s ^ (s >> XS_SHIFT_C);
   return s;
endfunction

function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
   return (h ^ {56'd0, b}) * FNV_PRIME;
endfunction

function automatic logic [63:0] plain_hash(input byte_q p);
   logic [63:0] h;
   h = FNV_OFFSET_BASIS;
   foreach (p[i]) h = fnv_step(h, p[i]);
   return h;
endfunction

// ciphertext of a whole string started with key k
function automatic void encode_string(input logic [63:0] k, input byte_q p, output byte_q c);
   logic [63:0] g;
   logic [7:0]  n;
   g = (k != 64'd0) ? k : ZERO_KEY_SUBST;
   n = 8'd0;
   c = {};
   foreach (p[i]) begin
      g = xs_next(g);
      c = {c, p[i] ^ g[7:0] ^ n};
      n = n + 8'd1;
   end
endfunction

class cipher_scoreboard;
   logic [63:0] key;
   logic        dir;
   logic [63:0] exp_hash;
   logic [63:0] gen;
   logic [7:0]  idx;
   logic [63:0] hash;
   rsp_type     pending_q[$];
   int unsigned errors;
   int unsigned checked;
   int unsigned match_count;

   function new();
      key = ZERO_KEY_SUBST;
      dir = DIR_ENCODE;
      exp_hash = 64'd0;
      gen = ZERO_KEY_SUBST;
      idx = 8'd0;
      hash = FNV_OFFSET_BASIS;
      errors = 0;
      checked = 0;
      match_count = 0;
   endfunction

   function void write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      case (index)
         CSR_KEY: key = value;
         CSR_DIRECTION: dir = value[0];
         CSR_EXPECTED_HASH: exp_hash = value;
         default: ;
      endcase
   endfunction

   function void note_request(input req_type r);
      rsp_type    e;
      logic [7:0] plain;
      if (r.first) begin
         gen = (key != 64'd0) ? key : ZERO_KEY_SUBST;
         idx = 8'd0;
         hash = FNV_OFFSET_BASIS;
      end
      gen = xs_next(gen);
      e.out_byte = r.data_byte ^ gen[7:0] ^ idx;
      plain = (dir == DIR_DECODE) ? e.out_byte : r.data_byte;
      hash = fnv_step(hash, plain);
      idx = idx + 8'd1;
      e.running_hash = hash;
      e.hash_match = r.last && (hash == exp_hash);
      e.end_of_string = r.last;
      pending_q = {pending_q, e};
   endfunction

   function void check_response(input rsp_type a);
      rsp_type e;
      checked++;
      if (pending_q.size() == 0) begin
         if (errors < 10)
            $display("tb: response with nothing pending: byte %02h hash %016h",
                     a.out_byte, a.running_hash);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      if (e.hash_match) match_count++;
      if (a.out_byte !== e.out_byte || a.running_hash !== e.running_hash ||
          a.hash_match !== e.hash_match || a.end_of_string !== e.end_of_string) begin
         if (errors < 10)
            $display({"tb: mismatch: expected byte %02h hash %016h match %0b eos %0b,",
                      " got byte %02h hash %016h match %0b eos %0b"},
                     e.out_byte, e.running_hash, e.hash_match, e.end_of_string,
                     a.out_byte, a.running_hash, a.hash_match, a.end_of_string);
         errors++;
      end
   endfunction
endclass

module tb;
   import xks_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {STR_WELL, STR_NO_LAST, STR_NO_FIRST, STR_NOISE} str_kind_e;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   cipher_scoreboard sb = new();

   bit          req_took = 0;
   bit          rsp_took = 0;
   bit          csr_took = 0;
   int unsigned quiet_cycles = 0;
   int unsigned req_count = 0;
   int unsigned csr_count = 0;
   int unsigned send_pct = 0;
   int unsigned stall_pct = 0;
   logic [7:0]  hold_token = 8'd0;
   logic [7:0]  hold_seen = 8'd0;
   int unsigned hold_left = 0;

   xorshift_keystream_string_cipher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      rsp_took = !reset && rsp_valid && !rsp_stall;
      csr_took = !reset && csr_valid && csr_ready;
      if (req_took) begin
         sb.note_request(req_data);
         req_count++;
      end
      if (rsp_took) sb.check_response(rsp_data);
      if (csr_took) begin
         sb.write_reg(csr_index, csr_data);
         csr_count++;
      end
      if (reset || req_took || rsp_took || csr_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: no handshake for %0d cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // receiver; a new hold token starts a long stall
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic req_type make_req(input logic [7:0] d, input logic f, input logic l);
      req_type r;
      r.data_byte = d;
      r.first = f;
      r.last = l;
      return r;
   endfunction

   task automatic drive_request(input req_type r);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (!req_took) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      while (!csr_took) @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                            input logic [63:0] k, input logic d, input int n,
                            input bit hold, input bit wrap);
      req_type   stream[$];
      byte_q     plain;
      byte_q     sent;
      int        target_at;
      int        len;
      bit        placed;
      bit        long_done;
      str_kind_e kind;
      int        pick;
      logic      f;
      logic      l;
      drain();
      len = $urandom_range(1, 12);
      repeat (len) plain = {plain, 8'($urandom)};
      if (d == DIR_DECODE) encode_string(k, plain, sent);
      else sent = plain;
      write_csr(CSR_KEY, k);
      write_csr(CSR_DIRECTION, {32'($urandom), 31'($urandom), d});
      write_csr(CSR_EXPECTED_HASH, plain_hash(plain));
      send_pct = s_pct;
      stall_pct <= r_pct;
      target_at = $urandom_range(n / 2);
      placed = 0;
      long_done = !wrap;
      while (stream.size() < n) begin
         if (!placed && stream.size() >= target_at) begin
            foreach (sent[i])
               stream = {stream, make_req(sent[i], i == 0, i == sent.size() - 1)};
            placed = 1;
         end else begin
            pick = $urandom_range(99);
            kind = (pick < 75) ? STR_WELL : (pick < 85) ? STR_NO_LAST :
                   (pick < 93) ? STR_NO_FIRST : STR_NOISE;
            if (!long_done) begin
               len = $urandom_range(257, 300);
               kind = STR_WELL;
               long_done = 1;
            end else begin
               len = $urandom_range(1, 24);
            end
            for (int i = 0; i < len; i++) begin
               f = (i == 0) && kind != STR_NO_FIRST;
               l = (i == len - 1) && kind != STR_NO_LAST;
               if (kind == STR_NOISE) begin
                  f = ($urandom_range(3) == 0);
                  l = ($urandom_range(3) == 0);
               end
               stream = {stream, make_req(8'($urandom), f, l)};
            end
         end
      end
      foreach (stream[i]) begin
         if (hold && i == 40) hold_token <= hold_token + 8'd1;
         drive_request(stream[i]);
      end
   endtask

   initial begin
      byte_q dir_plain;
      byte_q dir_sent;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state, stream without a leading first, bytes after last
      drive_request(make_req(8'h00, 1'b0, 1'b0));
      drive_request(make_req(8'hFF, 1'b0, 1'b0));
      drive_request(make_req(8'h3C, 1'b0, 1'b1));
      drive_request(make_req(8'hC3, 1'b0, 1'b0));
      drive_request(make_req(8'hFF, 1'b1, 1'b1));
      drive_request(make_req(8'h00, 1'b1, 1'b0));
      drive_request(make_req(8'h80, 1'b0, 1'b0));
      drive_request(make_req(8'h01, 1'b0, 1'b1));
      drain();

      // zero key, decode, hash match
      dir_plain = '{8'h00, 8'hFF, 8'h5A};
      encode_string(64'd0, dir_plain, dir_sent);
      write_csr(CSR_KEY, 64'd0);
      write_csr(CSR_DIRECTION, {63'd0, DIR_DECODE});
      write_csr(CSR_EXPECTED_HASH, plain_hash(dir_plain));
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      foreach (dir_sent[i]) drive_request(make_req(dir_sent[i], i == 0, i == 2));
      drive_request(make_req(8'h11, 1'b1, 1'b0));
      drive_request(make_req(8'h22, 1'b0, 1'b0));
      drain();

      // key changed mid-string: old generator runs on until the next first
      write_csr(CSR_KEY, '1);
      write_csr(CSR_EXPECTED_HASH, '1);
      write_csr(CSR_DIRECTION, {63'd0, DIR_ENCODE});
      drive_request(make_req(8'h33, 1'b0, 1'b0));
      drive_request(make_req(8'h44, 1'b0, 1'b1));
      drive_request(make_req(8'h55, 1'b1, 1'b1));
      drain();
      dir_plain = '{8'h12};
      write_csr(CSR_EXPECTED_HASH, plain_hash(dir_plain));
      drive_request(make_req(8'h12, 1'b1, 1'b1));

      run_phase(0, 0, {$urandom, $urandom}, DIR_ENCODE, 140, 0, 1);
      run_phase(62, 0, '1, DIR_DECODE, 140, 0, 0);
      run_phase(0, 62, 64'd0, DIR_ENCODE, 140, 0, 1);
      run_phase(6, 6, 64'd1, DIR_DECODE, 140, 0, 0);
      run_phase(0, 0, {$urandom, $urandom}, DIR_DECODE, 140, 1, 0);
      run_phase(62, 0, {$urandom, $urandom}, DIR_ENCODE, 140, 0, 0);
      run_phase(0, 62, {$urandom, $urandom}, DIR_ENCODE, 140, 0, 1);
      run_phase(6, 6, {$urandom, $urandom}, DIR_DECODE, 140, 0, 0);
      drain();
      repeat (10) @(negedge clock);

      $display("tb: %0d requests, %0d responses, %0d hash matches, %0d register writes",
               req_count, sb.checked, sb.match_count, csr_count);
      $display("tb: encode and decode, zero and extreme keys, index wrap, long output hold");
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d errors, %0d responses missing", sb.errors, sb.pending_q.size());
         $display("tb: failure");
      end
      $finish;
   end
endmodule
